// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the level meter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition b holds in the same cycle as a.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle check failed");

// The condition b holds in the cycle after a.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/wrms_pkg.sv -----
// ----------------------------------------------------------------------------
// wrms_pkg
// Item types, queue status and back end states of the windowed RMS meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrms_pkg;

	typedef struct packed {
		logic signed [15:0] sample_value;
		logic               end_of_stream;
	} sample_item_t;

	typedef struct packed {
		logic [15:0] rms_level;
		logic [15:0] samples_in_window;
		logic        partial_window;
	} result_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_DIV,
		BE_SQRT,
		BE_WRITE
	} back_state_t;

	localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd2940;

endpackage

// ----- rtl/wrms_front.sv -----
// ----------------------------------------------------------------------------
// wrms_front
// Squares each sample, accumulates the window and hands closed windows on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrms_front #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16,
	parameter int SUM_BITS    = 46
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  wrms_pkg::sample_item_t    sample_item,
	input  logic [15:0]               window_length,
	input  wrms_pkg::fifo_stat_t      stat,
	output logic                      push,
	output logic [SUM_BITS-1:0]       push_sum,
	output logic [COUNT_BITS-1:0]     push_count,
	output logic                      push_partial
);

	localparam logic [20:0] CAP = 21'((21'd1 << COUNT_BITS) - 21'd1);

	logic [31:0]              raw_ext;
	logic [SAMPLE_BITS-1:0]   raw;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] sq;
	logic                     accept;

	logic                     valid_s1;
	logic [2*SAMPLE_BITS-1:0] sq_s1;
	logic                     eos_s1;

	logic [SUM_BITS-1:0]      sum_q;
	logic [COUNT_BITS-1:0]    cnt_q;

	logic [SUM_BITS:0]        sum_ext;
	logic [SUM_BITS-1:0]      sum_sat;
	logic [COUNT_BITS-1:0]    cnt_next;
	logic [20:0]              len_ext;
	logic [COUNT_BITS-1:0]    eff_len;
	logic                     full;
	logic                     close;

	// One item is in the multiply stage at a time; the queue must have room
	// before an item is taken, since it may close a window.
	assign sample_stall = valid_s1 | stat.full;
	assign accept       = sample_valid & ~sample_stall;

	assign raw_ext = {16'd0, sample_item.sample_value};
	assign raw     = raw_ext[SAMPLE_BITS-1:0];
	// The most negative code negates to itself, which is its magnitude.
	assign mag     = raw[SAMPLE_BITS-1] ?
		(~raw + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : raw;
	assign sq      = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1  <= sq;
			eos_s1 <= sample_item.end_of_stream;
		end
	end

	always_comb begin
		len_ext = (window_length == 16'd0) ? 21'd1 : {5'd0, window_length};
		if (len_ext > CAP) begin
			len_ext = CAP;
		end
	end
	assign eff_len = len_ext[COUNT_BITS-1:0];

	assign sum_ext  = {1'b0, sum_q} + {{(SUM_BITS+1-2*SAMPLE_BITS){1'b0}}, sq_s1};
	assign sum_sat  = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
	assign cnt_next = cnt_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
	assign full     = cnt_next >= eff_len;
	assign close    = valid_s1 & (full | eos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (valid_s1) begin
			if (close) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_sat;
				cnt_q <= cnt_next;
			end
		end
	end

	assign push         = close;
	assign push_sum     = sum_sat;
	assign push_count   = cnt_next;
	assign push_partial = ~full;

endmodule

// ----- rtl/wrms_fifo.sv -----
// ----------------------------------------------------------------------------
// wrms_fifo
// Two-entry queue of closed windows between the accumulator and the math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrms_fifo #(
	parameter int WIDTH = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     pop_data,
	output wrms_pkg::fifo_stat_t stat
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign stat.full  = count_q == (PTR_W+1)'(DEPTH);
	assign stat.empty = count_q == '0;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- rtl/wrms_back.sv -----
// ----------------------------------------------------------------------------
// wrms_back
// Divides a window sum by its count, takes the integer square root and
// holds the result item in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrms_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16,
	parameter int SUM_BITS    = 46
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wrms_pkg::fifo_stat_t   stat,
	output logic                   pop,
	input  logic [SUM_BITS-1:0]    pop_sum,
	input  logic [COUNT_BITS-1:0]  pop_count,
	input  logic                   pop_partial,
	output logic                   result_valid,
	input  logic                   result_stall,
	output wrms_pkg::result_item_t result_item
);

	localparam int STEP_W = $clog2(SUM_BITS);

	wrms_pkg::back_state_t state_q;
	wrms_pkg::back_state_t state_d;

	logic [SUM_BITS-1:0]    quo_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [COUNT_BITS-1:0]  den_q;
	logic                   partial_q;
	logic                   zero_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_BITS+1:0] srem_q;
	logic [SAMPLE_BITS-1:0] root_q;

	logic                   out_free;
	logic                   load_out;
	logic                   step_last;

	logic [COUNT_BITS:0]    div_t;
	logic [COUNT_BITS:0]    div_diff;
	logic                   div_ge;

	logic [SAMPLE_BITS+1:0] sq_t;
	logic [SAMPLE_BITS+1:0] sq_trial;
	logic                   sq_ge;

	logic [31:0]            root_ext;
	logic [31:0]            count_ext;

	wrms_pkg::result_item_t result_q;
	logic                   result_valid_q;

	assign out_free  = ~result_valid_q | ~result_stall;
	assign step_last = step_q == '0;

	// Restoring division, one quotient bit per cycle; the dividend shifts
	// out of the top of quo_q as the quotient shifts in at the bottom.
	assign div_t    = {rem_q, quo_q[SUM_BITS-1]};
	assign div_diff = div_t - {1'b0, den_q};
	assign div_ge   = div_t >= {1'b0, den_q};

	// Digit-by-digit square root over the quotient, two bits per cycle.
	assign sq_t     = {srem_q[SAMPLE_BITS-1:0], quo_q[2*SAMPLE_BITS-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = sq_t >= sq_trial;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wrms_pkg::BE_IDLE: begin
				if (!stat.empty) begin
					state_d = wrms_pkg::BE_DIV;
				end
			end
			wrms_pkg::BE_DIV: begin
				if (step_last) begin
					state_d = wrms_pkg::BE_SQRT;
				end
			end
			wrms_pkg::BE_SQRT: begin
				if (step_last) begin
					state_d = wrms_pkg::BE_WRITE;
				end
			end
			wrms_pkg::BE_WRITE: begin
				if (out_free) begin
					state_d = wrms_pkg::BE_IDLE;
				end
			end
			default: begin
				state_d = wrms_pkg::BE_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			wrms_pkg::BE_IDLE:  pop      = ~stat.empty;
			wrms_pkg::BE_WRITE: load_out = out_free;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrms_pkg::BE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wrms_pkg::BE_IDLE: begin
				quo_q     <= pop_sum;
				rem_q     <= '0;
				den_q     <= pop_count;
				partial_q <= pop_partial;
				zero_q    <= pop_count == '0;
				step_q    <= STEP_W'(SUM_BITS - 1);
			end
			wrms_pkg::BE_DIV: begin
				quo_q <= {quo_q[SUM_BITS-2:0], div_ge};
				rem_q <= div_ge ? div_diff[COUNT_BITS-1:0] : div_t[COUNT_BITS-1:0];
				if (step_last) begin
					step_q <= STEP_W'(SAMPLE_BITS - 1);
					srem_q <= '0;
					root_q <= '0;
				end else begin
					step_q <= step_q - {{(STEP_W-1){1'b0}}, 1'b1};
				end
			end
			wrms_pkg::BE_SQRT: begin
				quo_q  <= quo_q << 2;
				srem_q <= sq_ge ? (sq_t - sq_trial) : sq_t;
				root_q <= {root_q[SAMPLE_BITS-2:0], sq_ge};
				step_q <= step_q - {{(STEP_W-1){1'b0}}, 1'b1};
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign root_ext  = {{(32-SAMPLE_BITS){1'b0}}, root_q};
	assign count_ext = {{(32-COUNT_BITS){1'b0}}, den_q};

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.rms_level         <= zero_q ? 16'd0 : root_ext[15:0];
			result_q.samples_in_window <= count_ext[15:0];
			result_q.partial_window    <= partial_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

// ----- rtl/windowed_rms_level_meter_core.sv -----
// ----------------------------------------------------------------------------
// windowed_rms_level_meter_core
// Windowed RMS level meter: sums sample squares over non-overlapping windows
// and reports floor(sqrt(floor(sum / count))) for each window.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   sample    in         sample_valid / stall      sample_item (value, eos)
//   result    out        result_valid / stall      result_item (rms, count, part)
//   config    in         cfg_wr_en                 cfg_wr_data (window length)
//
// A sample item is not taken while the one before it is still in flight: it is
// squared and registered, then added into the window sum, closing the window if due.
// Each closed window is taken from the queue, divided and square-rooted by the
// sequencer; a two-entry queue overlaps that with the next window. Input also
// stalls while the queue is full.
// Reset clears all sums and counts and sets the window length to 2940.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module windowed_rms_level_meter_core #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  wrms_pkg::sample_item_t sample_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output wrms_pkg::result_item_t result_item,
	input  logic                   cfg_wr_en,
	input  logic [15:0]            cfg_wr_data
);

	localparam int FULL_BITS = 2*SAMPLE_BITS + COUNT_BITS - 2;
	// Above 64 bits the sum saturates at the largest 64-bit value.
	localparam int SUM_BITS  = (FULL_BITS > 64) ? 64 : FULL_BITS;
	localparam int Q_WIDTH   = SUM_BITS + COUNT_BITS + 1;

	logic [15:0]           window_length_q;
	wrms_pkg::fifo_stat_t  stat;
	logic                  push;
	logic [SUM_BITS-1:0]   push_sum;
	logic [COUNT_BITS-1:0] push_count;
	logic                  push_partial;
	logic                  pop;
	logic [Q_WIDTH-1:0]    pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= wrms_pkg::WINDOW_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			window_length_q <= cfg_wr_data;
		end
	end

	wrms_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.SUM_BITS    (SUM_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_item   (sample_item),
		.window_length (window_length_q),
		.stat          (stat),
		.push          (push),
		.push_sum      (push_sum),
		.push_count    (push_count),
		.push_partial  (push_partial)
	);

	wrms_fifo #(
		.WIDTH (Q_WIDTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_sum, push_count, push_partial}),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	wrms_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS),
		.SUM_BITS    (SUM_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.pop          (pop),
		.pop_sum      (pop_data[Q_WIDTH-1 -: SUM_BITS]),
		.pop_count    (pop_data[COUNT_BITS:1]),
		.pop_partial  (pop_data[0]),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// A closed window must always find room in the queue.
	`ASSERT_SAME(a_push_room, clk, arst_n, push, !stat.full)
	// The sequencer only takes a window that is there.
	`ASSERT_SAME(a_pop_data, clk, arst_n, pop, !stat.empty)
	// A taken sample blocks the next cycle while its square is added into the window sum.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, sample_valid && !sample_stall, sample_stall)

endmodule
